>>> design/lst_pkg.sv
// Shared types and constants for the latency statistics tracker.
// No dependencies; used by every module under design/.
package lst_pkg;

  // Window limit, widths, step counts and root seed
  localparam int unsigned CNT_W = 20;
  localparam logic [CNT_W-1:0] COUNT_LIMIT = 20'd1000000;
  localparam int unsigned DIV_STEPS = 64;
  localparam int unsigned ROOT_STEPS = 16;
  localparam logic [31:0] ROOT_SEED = 32'h4000_0000;

  // Input item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // Input word
  typedef struct packed {
    logic        kind;
    logic [31:0] start_time;
    logic [31:0] stop_time;
  } lst_in_t;

  // Result word
  typedef struct packed {
    logic [31:0]      last_latency;
    logic [31:0]      min_latency;
    logic [31:0]      max_latency;
    logic [31:0]      mean_latency;
    logic [31:0]      jitter;
    logic [CNT_W-1:0] count;
  } lst_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic clear;
    logic update;
    logic acc;
    logic reseed;
    logic reseed_sq;
    logic div_start;
    logic mean_load;
    logic mul_load;
    logic mul_mean;
    logic var_load;
    logic root_step;
    logic load_out;
  } lst_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic in_window;
    logic multi;
    logic div_busy;
    logic div_done;
    logic root_last;
  } lst_stat_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } lst_div_stat_t;

endpackage

>>> design/latency_statistics_tracker.sv
// Latency statistics tracker: takes one word at a time; the time a sample
// word takes from its acceptance to the next acceptance is set mostly by the
// 64-step shared divider (sum and square sum divided in parallel) and the
// 16-step root unit; the first sample of a window skips the root, a window
// rollover and a clear word skip both, and every word waits in its last state
// until the output register is free. Each word
// gives one result word, held in an output register so the result may wait
// while the next word is taken. Depends on lst_pkg, lst_ctrl, lst_datapath.
module latency_statistics_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lst_pkg::lst_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lst_pkg::lst_out_t out_data
);

  lst_pkg::lst_cmd_t  cmd;
  lst_pkg::lst_stat_t stat;

  lst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lst_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

`ifndef NO_ASSERTIONS
  // Only one word in flight
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in flight");

  // Divider is never restarted while running
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

  // Empty window reports zero minimum
  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.count == '0 |-> out_data.min_latency == 32'd0)
    else $error("nonzero minimum with empty window");

  // Window count stays below the limit
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.count < lst_pkg::COUNT_LIMIT)
    else $error("window count reached limit");
`endif

endmodule

>>> design/lst_div.sv
// Two-lane restoring divider, 64-bit dividends by a shared 20-bit divisor.
// One quotient bit per lane per cycle. Depends on lst_pkg.
module lst_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [63:0]                 dividend_a,
  input  logic [63:0]                 dividend_b,
  input  logic [lst_pkg::CNT_W-1:0]   divisor,
  output logic [63:0]                 quotient_a,
  output logic [63:0]                 quotient_b,
  output lst_pkg::lst_div_stat_t      stat
);

  logic [lst_pkg::CNT_W-1:0] rem_a;
  logic [lst_pkg::CNT_W-1:0] rem_b;
  logic [lst_pkg::CNT_W-1:0] dvs;
  logic [5:0]                cnt;
  logic                      busy;
  logic                      done;

  logic [lst_pkg::CNT_W:0]   trial_a;
  logic [lst_pkg::CNT_W:0]   trial_b;
  logic                      fit_a;
  logic                      fit_b;

  // Shift in the next dividend bit and try the subtract
  always_comb begin
    trial_a = {rem_a, quotient_a[63]};
    trial_b = {rem_b, quotient_b[63]};
    fit_a   = trial_a >= {1'b0, dvs};
    fit_b   = trial_b >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(lst_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient bits shift into the dividend registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_a      <= '0;
      rem_b      <= '0;
      dvs        <= divisor;
      quotient_a <= dividend_a;
      quotient_b <= dividend_b;
    end else if (busy) begin
      rem_a      <= fit_a ? lst_pkg::CNT_W'(trial_a - {1'b0, dvs})
                          : trial_a[lst_pkg::CNT_W-1:0];
      rem_b      <= fit_b ? lst_pkg::CNT_W'(trial_b - {1'b0, dvs})
                          : trial_b[lst_pkg::CNT_W-1:0];
      quotient_a <= {quotient_a[62:0], fit_a};
      quotient_b <= {quotient_b[62:0], fit_b};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> design/lst_datapath.sv
// Datapath: statistic registers, shared multiplier, divider, root unit and
// result register. Depends on lst_pkg and lst_div.
module lst_datapath (
  input  logic                clk,
  input  logic                rst,
  input  lst_pkg::lst_in_t    in_data,
  input  lst_pkg::lst_cmd_t   cmd,
  output lst_pkg::lst_stat_t  stat,
  output lst_pkg::lst_out_t   out_data
);

  // Captured sample
  logic                      kind;
  logic [31:0]               elapsed;

  // Statistics state
  logic [31:0]               last_value;
  logic [31:0]               min_value;
  logic [31:0]               max_value;
  logic [31:0]               mean_value;
  logic [31:0]               jitter_value;
  logic [lst_pkg::CNT_W-1:0] sample_total;
  logic [63:0]               sum_acc;
  logic [63:0]               square_sum_acc;

  // Working registers
  logic [63:0]               prod;
  logic [63:0]               rem;
  logic [31:0]               root;
  logic [31:0]               rbit;
  logic [3:0]                rcnt;

  logic [63:0]               quot_a;
  logic [63:0]               quot_b;
  lst_pkg::lst_div_stat_t    div_stat;

  logic [31:0]               mul_op;
  logic [32:0]               trial;
  logic                      fit;
  logic [31:0]               root_next;

  lst_div u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (cmd.div_start),
    .dividend_a (sum_acc),
    .dividend_b (square_sum_acc),
    .divisor    (sample_total),
    .quotient_a (quot_a),
    .quotient_b (quot_b),
    .stat       (div_stat)
  );

  // Multiplier operand select and root step: try root + bit against the remainder
  always_comb begin
    mul_op    = cmd.mul_mean ? mean_value : elapsed;
    trial     = {1'b0, root} + {1'b0, rbit};
    fit       = rem >= {31'b0, trial};
    root_next = fit ? ((root >> 1) + rbit) : (root >> 1);
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind    <= in_data.kind;
      elapsed <= in_data.stop_time - in_data.start_time;
    end
  end

  // Statistics state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      last_value     <= '0;
      min_value      <= '1;
      max_value      <= '0;
      mean_value     <= '0;
      jitter_value   <= '0;
      sample_total   <= '0;
      sum_acc        <= '0;
      square_sum_acc <= '0;
    end else begin
      if (cmd.update) begin
        last_value   <= elapsed;
        sample_total <= sample_total + 1'b1;
        if (elapsed < min_value) begin
          min_value <= elapsed;
        end
        if (elapsed > max_value) begin
          max_value <= elapsed;
        end
      end
      if (cmd.acc) begin
        sum_acc        <= sum_acc + {32'b0, elapsed};
        square_sum_acc <= square_sum_acc + prod;
      end
      if (cmd.reseed) begin
        sum_acc      <= {32'b0, mean_value};
        sample_total <= lst_pkg::CNT_W'(1);
      end
      if (cmd.reseed_sq) begin
        square_sum_acc <= prod;
      end
      if (cmd.mean_load) begin
        mean_value <= quot_a[31:0];
      end
      if (cmd.root_step && rcnt == 4'(lst_pkg::ROOT_STEPS - 1)) begin
        jitter_value <= root_next;
      end
    end
  end

  // Shared multiplier and root unit
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod <= {32'b0, mul_op} * {32'b0, mul_op};
    end
    if (cmd.var_load) begin
      rem  <= quot_b - prod;
      root <= '0;
      rbit <= lst_pkg::ROOT_SEED;
      rcnt <= '0;
    end else if (cmd.root_step) begin
      if (fit) begin
        rem <= rem - {31'b0, trial};
      end
      root <= root_next;
      rbit <= rbit >> 2;
      rcnt <= rcnt + 4'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.last_latency <= last_value;
      out_data.min_latency  <= (sample_total == '0) ? 32'd0 : min_value;
      out_data.max_latency  <= max_value;
      out_data.mean_latency <= mean_value;
      out_data.jitter       <= jitter_value;
      out_data.count        <= sample_total;
    end
  end

  // Status
  always_comb begin
    stat.is_clear  = kind == lst_pkg::KIND_CLEAR;
    stat.in_window = (sample_total < lst_pkg::COUNT_LIMIT) && (sample_total != '0);
    stat.multi     = sample_total > lst_pkg::CNT_W'(1);
    stat.div_busy  = div_stat.busy;
    stat.div_done  = div_stat.done;
    stat.root_last = rcnt == 4'(lst_pkg::ROOT_STEPS - 1);
  end

endmodule

>>> design/lst_ctrl.sv
// Controller: sequences one word at a time through clear or update, reseed,
// divide and root steps and owns both handshakes. Depends on lst_pkg.
module lst_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  lst_pkg::lst_stat_t  stat,
  output lst_pkg::lst_cmd_t   cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_BRANCH,
    ST_RESEED,
    ST_DSTART,
    ST_DIV,
    ST_MSQ,
    ST_VAR,
    ST_ROOT,
    ST_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_ready = state == ST_IDLE;
  assign out_free = !out_valid || out_ready;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        if (stat.is_clear) begin
          cmd.clear  = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.update   = 1'b1;
          cmd.mul_load = 1'b1;
          state_next   = ST_BRANCH;
        end
      end
      ST_BRANCH: begin
        if (stat.in_window) begin
          cmd.acc    = 1'b1;
          state_next = ST_DSTART;
        end else begin
          cmd.reseed   = 1'b1;
          cmd.mul_load = 1'b1;
          cmd.mul_mean = 1'b1;
          state_next   = ST_RESEED;
        end
      end
      ST_RESEED: begin
        cmd.reseed_sq = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.mean_load = 1'b1;
          state_next    = stat.multi ? ST_MSQ : ST_DONE;
        end
      end
      ST_MSQ: begin
        cmd.mul_load = 1'b1;
        cmd.mul_mean = 1'b1;
        state_next   = ST_VAR;
      end
      ST_VAR: begin
        cmd.var_load = 1'b1;
        state_next   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
